@@ hw/rtl/ts_continuity_reorder_unit_macros.svh @@
// Assertion macros for the continuity reorder unit checker
`ifndef TS_CONTINUITY_REORDER_UNIT_MACROS_SVH
`define TS_CONTINUITY_REORDER_UNIT_MACROS_SVH

// same-cycle implication, sampled on i_clk, off during reset
`define TSCR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on i_clk, off during reset
`define TSCR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/tscr_pkg.sv @@
// Types and constants of the continuity reorder unit
package tscr_pkg;

    localparam int unsigned PID_SPACE = 8192;
    localparam int unsigned PID_BITS  = 13;
    localparam int unsigned CC_BITS   = 4;
    localparam int unsigned MAX_OUT   = 17;
    localparam int unsigned REL_BITS  = 5;

    localparam logic [7:0]          SYNC_MARK = 8'h47;
    localparam logic [PID_BITS-1:0] PID_NULL  = 13'h1fff;
    localparam logic [PID_BITS-1:0] PID_IIP   = 13'h1ff0;
    localparam logic [REL_BITS-1:0] REL_LIMIT = REL_BITS'(MAX_OUT - 1);

    localparam logic [2:0] ACT_DELIVERED = 3'd0;
    localparam logic [2:0] ACT_RELEASED  = 3'd1;
    localparam logic [2:0] ACT_HELD      = 3'd2;
    localparam logic [2:0] ACT_BAD_SYNC  = 3'd3;
    localparam logic [2:0] ACT_ERROR     = 3'd4;
    localparam logic [2:0] ACT_NULL_PID  = 3'd5;
    localparam logic [2:0] ACT_HOLD_FULL = 3'd6;

    typedef struct packed {
        logic [7:0]          sync_value;
        logic                error_flag;
        logic                unit_start;
        logic [PID_BITS-1:0] packet_id;
        logic [CC_BITS-1:0]  cont_count;
        logic [7:0]          buffer_tag;
    } t_in_item;

    typedef struct packed {
        logic [7:0]          out_tag;
        logic [PID_BITS-1:0] out_pid;
        logic [2:0]          action;
        logic [31:0]         packet_total;
        logic                last;
    } t_out_item;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EVAL,
        ST_FLUSH_RD,
        ST_FLUSH_CMP,
        ST_REL_RD,
        ST_REL_CMP,
        ST_FREE,
        ST_FIN
    } t_state;

endpackage

@@ hw/rtl/tscr_ram.sv @@
// Generic single-write, single-read RAM with registered read data
module tscr_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ hw/rtl/ts_continuity_reorder_unit.sv @@
// Top level: per-PID continuity check, count and reorder of transport-stream packets
//
// Input: a header plus buffer tag is taken on a clock edge with start high and busy
// low. Results come out one per strobe cycle on o_result; last marks the final
// result of an item. The receiver cannot hold results off.
// A bad sync item goes straight to ST_FIN and its result is registered out. Other
// items read the per-PID word; unless dropped for an error or a null PID, a
// sequencer then walks the hold store one entry at a time through a single RAM
// read port: a flush on new PID or unit start reads and compares every entry, a
// hold looks for a free entry, and each release round searches for the expected
// continuity count (at most 16 releases per item). busy stays high for the whole
// item and drops in the same cycle as the final strobe, when the next item may
// start; no new item is taken before the last one is finished.
// Reset: a clearing pass writes zero over all 8192 per-PID words, one a cycle,
// with busy high throughout; hold store valid bits clear at once.
module ts_continuity_reorder_unit
    import tscr_pkg::*;
#(
    parameter int unsigned HOLD_DEPTH = 16,
    parameter int unsigned TAG_BITS   = 8,
    parameter int unsigned COUNT_BITS = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    input  t_in_item  i_data,
    output logic      o_strobe,
    output t_out_item o_result
);
    localparam int unsigned TW  = (TAG_BITS < 8) ? TAG_BITS : 8;
    localparam int unsigned HW  = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;
    localparam int unsigned PW  = COUNT_BITS + CC_BITS + 1;
    localparam int unsigned HDW = PID_BITS + CC_BITS + TW;
    localparam int unsigned AW  = $clog2(PID_SPACE);
    localparam logic [HW-1:0] LAST_IDX = HW'(HOLD_DEPTH - 1);
    localparam logic [AW-1:0] LAST_PID = AW'(PID_SPACE - 1);

    t_state r_state, n_state;

    logic [PID_BITS-1:0]   r_pid, n_pid;
    logic [CC_BITS-1:0]    r_cc, n_cc;
    logic [TW-1:0]         r_tag, n_tag;
    logic                  r_err, n_err;
    logic                  r_ustart, n_ustart;
    logic                  r_bad, n_bad;
    logic                  r_seen, n_seen;
    logic [CC_BITS-1:0]    r_exp, n_exp;
    logic [COUNT_BITS-1:0] r_total, n_total;
    logic [HW-1:0]         r_idx, n_idx;
    logic [REL_BITS-1:0]   r_rel, n_rel;
    logic [HOLD_DEPTH-1:0] r_valid, n_valid;
    t_out_item             r_pend, n_pend;
    t_out_item             r_out, n_out;
    logic                  r_strobe, n_strobe;
    logic [AW-1:0]         r_clr, n_clr;

    logic                  pid_we;
    logic [AW-1:0]         pid_waddr, pid_raddr;
    logic [PW-1:0]         pid_wdata, pid_q;
    logic                  hold_we;
    logic [HDW-1:0]        hold_wdata, hold_q;

    logic                  q_seen;
    logic [CC_BITS-1:0]    q_exp;
    logic [COUNT_BITS-1:0] q_cnt, sat_cnt;
    logic [PID_BITS-1:0]   h_pid;
    logic [CC_BITS-1:0]    h_cc;
    logic [TW-1:0]         h_tag;
    logic                  pid_hit, rel_hit, accept;
    logic [63:0]           total_wide;
    logic [31:0]           total32;

    assign q_seen  = pid_q[PW-1];
    assign q_exp   = pid_q[COUNT_BITS +: CC_BITS];
    assign q_cnt   = pid_q[COUNT_BITS-1:0];
    assign sat_cnt = (&q_cnt) ? q_cnt : q_cnt + COUNT_BITS'(1);

    assign h_pid = hold_q[HDW-1 -: PID_BITS];
    assign h_cc  = hold_q[TW +: CC_BITS];
    assign h_tag = hold_q[TW-1:0];

    assign pid_hit = r_valid[r_idx] && (h_pid == r_pid);
    assign rel_hit = pid_hit && (h_cc == r_exp);
    assign accept  = start && (r_state == ST_IDLE);

    assign total_wide = 64'(r_total);
    assign total32    = total_wide[31:0];

    tscr_ram #(.WIDTH(PW), .DEPTH(PID_SPACE)) u_pid_ram (
        .i_clk   (i_clk),
        .i_we    (pid_we),
        .i_waddr (pid_waddr),
        .i_wdata (pid_wdata),
        .i_raddr (pid_raddr),
        .o_rdata (pid_q)
    );

    tscr_ram #(.WIDTH(HDW), .DEPTH(HOLD_DEPTH)) u_hold_ram (
        .i_clk   (i_clk),
        .i_we    (hold_we),
        .i_waddr (r_idx),
        .i_wdata (hold_wdata),
        .i_raddr (r_idx),
        .o_rdata (hold_q)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_clr == LAST_PID) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (start) begin
                    n_state = (i_data.sync_value != SYNC_MARK) ? ST_FIN : ST_EVAL;
                end
            end
            ST_EVAL: begin
                priority if (r_err || r_pid == PID_NULL || r_pid == PID_IIP) begin
                    n_state = ST_FIN;
                end else if (!q_seen || r_ustart) begin
                    n_state = ST_FLUSH_RD;
                end else if (q_exp == r_cc) begin
                    n_state = ST_REL_RD;
                end else begin
                    n_state = ST_FREE;
                end
            end
            ST_FLUSH_RD: n_state = ST_FLUSH_CMP;
            ST_FLUSH_CMP: begin
                n_state = (r_idx == LAST_IDX) ? ST_FIN : ST_FLUSH_RD;
            end
            ST_REL_RD: n_state = ST_REL_CMP;
            ST_REL_CMP: begin
                priority if (rel_hit) begin
                    n_state = (r_rel + REL_BITS'(1) == REL_LIMIT) ? ST_FIN : ST_REL_RD;
                end else if (r_idx == LAST_IDX) begin
                    n_state = ST_FIN;
                end else begin
                    n_state = ST_REL_RD;
                end
            end
            ST_FREE: begin
                if (!r_valid[r_idx] || r_idx == LAST_IDX) n_state = ST_FIN;
            end
            ST_FIN: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_pid      = r_pid;
        n_cc       = r_cc;
        n_tag      = r_tag;
        n_err      = r_err;
        n_ustart   = r_ustart;
        n_bad      = r_bad;
        n_seen     = r_seen;
        n_exp      = r_exp;
        n_total    = r_total;
        n_idx      = r_idx;
        n_rel      = r_rel;
        n_valid    = r_valid;
        n_pend     = r_pend;
        n_out      = r_out;
        n_strobe   = 1'b0;
        n_clr      = r_clr;
        pid_we     = 1'b0;
        pid_waddr  = r_pid;
        pid_wdata  = {r_seen, r_exp, r_total};
        pid_raddr  = (r_state == ST_IDLE) ? i_data.packet_id : r_pid;
        hold_we    = 1'b0;
        hold_wdata = {r_pid, r_cc, r_tag};

        unique case (r_state)
            ST_CLEAR: begin
                pid_we    = 1'b1;
                pid_waddr = r_clr;
                pid_wdata = '0;
                n_clr     = r_clr + AW'(1);
            end
            ST_IDLE: begin
                if (accept) begin
                    n_pid    = i_data.packet_id;
                    n_cc     = i_data.cont_count;
                    n_tag    = i_data.buffer_tag[TW-1:0];
                    n_err    = i_data.error_flag;
                    n_ustart = i_data.unit_start;
                    n_bad    = (i_data.sync_value != SYNC_MARK);
                    n_idx    = '0;
                    n_rel    = '0;
                    n_pend   = '{out_tag: 8'(i_data.buffer_tag[TW-1:0]),
                                 out_pid: i_data.packet_id, action: ACT_BAD_SYNC,
                                 packet_total: 32'd0, last: 1'b0};
                end
            end
            ST_EVAL: begin
                n_total = sat_cnt;
                n_seen  = q_seen;
                n_exp   = q_exp;
                n_pend.packet_total = 32'(64'(sat_cnt));
                priority if (r_err) begin
                    n_pend.action = ACT_ERROR;
                end else if (r_pid == PID_NULL || r_pid == PID_IIP) begin
                    n_pend.action = ACT_NULL_PID;
                end else if (!q_seen || r_ustart) begin
                    n_seen        = 1'b1;
                    n_exp         = r_cc + CC_BITS'(1);
                    n_pend.action = ACT_DELIVERED;
                end else if (q_exp == r_cc) begin
                    n_exp         = r_cc + CC_BITS'(1);
                    n_pend.action = ACT_DELIVERED;
                end else begin
                    n_pend.action = ACT_HOLD_FULL;
                end
            end
            ST_FLUSH_CMP: begin
                if (pid_hit) n_valid[r_idx] = 1'b0;
                n_idx = r_idx + HW'(1);
            end
            ST_REL_CMP: begin
                if (rel_hit) begin
                    n_valid[r_idx] = 1'b0;
                    n_exp          = h_cc + CC_BITS'(1);
                    n_rel          = r_rel + REL_BITS'(1);
                    n_idx          = '0;
                    n_out          = r_pend;
                    n_strobe       = 1'b1;
                    n_pend         = '{out_tag: 8'(h_tag), out_pid: r_pid,
                                       action: ACT_RELEASED, packet_total: total32,
                                       last: 1'b0};
                end else begin
                    n_idx = r_idx + HW'(1);
                end
            end
            ST_FREE: begin
                if (!r_valid[r_idx]) begin
                    hold_we        = 1'b1;
                    n_valid[r_idx] = 1'b1;
                    n_pend.action  = ACT_HELD;
                end else begin
                    n_idx = r_idx + HW'(1);
                end
            end
            ST_FIN: begin
                pid_we      = !r_bad;
                n_out       = r_pend;
                n_out.last  = 1'b1;
                n_strobe    = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLEAR;
            r_clr    <= '0;
            r_valid  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_valid  <= n_valid;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pid    <= n_pid;
        r_cc     <= n_cc;
        r_tag    <= n_tag;
        r_err    <= n_err;
        r_ustart <= n_ustart;
        r_bad    <= n_bad;
        r_seen   <= n_seen;
        r_exp    <= n_exp;
        r_total  <= n_total;
        r_idx    <= n_idx;
        r_rel    <= n_rel;
        r_pend   <= n_pend;
        r_out    <= n_out;
    end

    assign busy     = (r_state != ST_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_out;
endmodule

@@ hw/rtl/tscr_checker.sv @@
// Port checker for the continuity reorder unit, with its bind
`include "ts_continuity_reorder_unit_macros.svh"

module tscr_checker
    import tscr_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      start,
    input logic      busy,
    input logic      o_strobe,
    input t_out_item o_result
);
    `TSCR_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted item did not raise busy")
    `TSCR_ASSERT_NOW(a_more_busy, o_strobe && !o_result.last, busy,
        "item ended before last result")
    `TSCR_ASSERT_NOW(a_act_range, o_strobe, o_result.action <= ACT_HOLD_FULL, "bad action code")
    `TSCR_ASSERT_NOW(a_bad_total, o_strobe && o_result.action == ACT_BAD_SYNC,
        o_result.packet_total == 32'd0 && o_result.last, "bad sync result malformed")
endmodule

bind ts_continuity_reorder_unit tscr_checker u_tscr_checker (.*);
